/* hw/rtl/fbm_value_noise_terrain_column_core_assert.svh */
// Assertion macros for the terrain column top level.
`ifndef FBM_VALUE_NOISE_TERRAIN_COLUMN_CORE_ASSERT_SVH
`define FBM_VALUE_NOISE_TERRAIN_COLUMN_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FVN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fvn assertion failed");

// Next-cycle implication, checked outside reset.
`define FVN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fvn assertion failed");

`endif

/* hw/rtl/fvn_pkg.sv */
// Shared types and constants of the terrain column generator.
`default_nettype none
package fvn_pkg;
    localparam logic [31:0] HASH_X      = 32'd374761393;
    localparam logic [31:0] HASH_Y      = 32'd668265263;
    localparam logic [31:0] HASH_S      = 32'd2246822519;
    localparam logic [31:0] HASH_MIX    = 32'd1274126177;
    localparam logic [31:0] SEED_STEP   = 32'd977;

    localparam logic [2:0] REG_SEED        = 3'd0;
    localparam logic [2:0] REG_SCALE       = 3'd1;
    localparam logic [2:0] REG_DEPTH       = 3'd2;
    localparam logic [2:0] REG_SEA         = 3'd3;
    localparam logic [2:0] REG_SURFACE     = 3'd4;
    localparam logic [2:0] REG_UNDERGROUND = 3'd5;
    localparam logic [2:0] REG_WATER       = 3'd6;

    typedef struct packed {
        logic [31:0] seed;
        logic [15:0] scale;
        logic [5:0]  dm1;
        logic [5:0]  sea;
        logic [15:0] surface;
        logic [15:0] under;
        logic [15:0] water;
    } t_cfg;
endpackage
`default_nettype wire

/* hw/rtl/fbm_value_noise_terrain_column_core.sv */
// Top level of the fractal value noise terrain column generator.
// A request passes the noise pipeline, height stage, height queue and column output register
// before its first level is offered. Levels leave at one per cycle while the receiver is
// ready; the column rate is set by the level emitter and by the noise pipeline, which takes
// no new request until its sum is handed on; the height stage never limits the rate.
// Reset is synchronous and active low; it loads the register defaults and empties all stages.
`default_nettype none
`include "fbm_value_noise_terrain_column_core_assert.svh"
module fbm_value_noise_terrain_column_core #(
    parameter int MAX_DEPTH    = 64,
    parameter int OCTAVE_COUNT = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [15:0] i_grid_x,
    input  wire  [15:0] i_grid_y,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [5:0]  o_level,
    output logic [15:0] o_cube_id,
    output logic [5:0]  o_terrain_height,
    output logic        o_last_level
);
    localparam int SW = OCTAVE_COUNT + 24;

    // Configuration registers. The user must write them only while the block is idle; the
    // block itself does not enforce this, and the datapath reads them live.
    logic [31:0] r_seed;
    logic [15:0] r_scale, r_surface, r_under, r_water;
    logic [6:0]  r_depth;
    logic [5:0]  r_sea;

    logic [6:0]    w_depth;
    logic [5:0]    w_dm1;
    fvn_pkg::t_cfg w_cfg;

    logic          w_s_valid, w_s_ready;
    logic [SW-1:0] w_s;
    logic          w_h_valid, w_h_ready, w_q_valid, w_q_ready;
    logic [5:0]    w_h, w_q;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= 32'd1337;
            r_scale   <= 16'd5243;
            r_depth   <= 7'd16;
            r_sea     <= 6'd5;
            r_surface <= 16'd1;
            r_under   <= 16'd2;
            r_water   <= 16'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fvn_pkg::REG_SEED:        r_seed    <= i_cfg_data;
                fvn_pkg::REG_SCALE:       r_scale   <= i_cfg_data[15:0];
                fvn_pkg::REG_DEPTH:       r_depth   <= i_cfg_data[6:0];
                fvn_pkg::REG_SEA:         r_sea     <= i_cfg_data[5:0];
                fvn_pkg::REG_SURFACE:     r_surface <= i_cfg_data[15:0];
                fvn_pkg::REG_UNDERGROUND: r_under   <= i_cfg_data[15:0];
                fvn_pkg::REG_WATER:       r_water   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The depth register is clamped to 2..MAX_DEPTH; the datapath uses depth minus one.
    assign w_depth = (r_depth < 7'd2) ? 7'd2 :
                     ((r_depth > 7'(MAX_DEPTH)) ? 7'(MAX_DEPTH) : r_depth);
    assign w_dm1   = 6'(w_depth - 7'd1);

    always_comb begin
        w_cfg.seed    = r_seed;
        w_cfg.scale   = r_scale;
        w_cfg.dm1     = w_dm1;
        w_cfg.sea     = r_sea;
        w_cfg.surface = r_surface;
        w_cfg.under   = r_under;
        w_cfg.water   = r_water;
    end

    // Front part: the noise pipeline takes one octave per cycle and hands the
    // weighted sum to the height stage, which then frees the noise stage for
    // the next request.
    fvn_noise #(.OCTAVE_COUNT(OCTAVE_COUNT)) u_noise (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_grid_x  (i_grid_x),
        .i_grid_y  (i_grid_y),
        .o_s_valid (w_s_valid),
        .i_s_ready (w_s_ready),
        .o_s       (w_s)
    );

    fvn_height #(.OCTAVE_COUNT(OCTAVE_COUNT)) u_height (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_s_valid (w_s_valid),
        .o_s_ready (w_s_ready),
        .i_s       (w_s),
        .o_h_valid (w_h_valid),
        .i_h_ready (w_h_ready),
        .o_h       (w_h)
    );

    // The queue of finished heights lets the front part run ahead of the emitter.
    fvn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_h_valid),
        .o_push_ready (w_h_ready),
        .i_data       (w_h),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_data       (w_q)
    );

    // Back part: walks the levels of each column with an output register, so the first level
    // of a new column can follow the last level of the previous one without an idle gap.
    fvn_column u_column (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_h_valid        (w_q_valid),
        .o_h_ready        (w_q_ready),
        .i_h              (w_q),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_level          (o_level),
        .o_cube_id        (o_cube_id),
        .o_terrain_height (o_terrain_height),
        .o_last_level     (o_last_level)
    );

    `FVN_ASSERT_NOW(a_height_range, o_valid, (o_terrain_height >= 6'd1) && (o_terrain_height <= w_dm1))
    `FVN_ASSERT_NOW(a_last_matches_depth, o_valid, o_last_level == (o_level == w_dm1))
    `FVN_ASSERT_NEXT(a_level_steps, o_valid && i_ready && !o_last_level, o_valid && (o_level == $past(o_level) + 6'd1))
endmodule
`default_nettype wire

/* hw/rtl/fvn_noise.sv */
// Front part: accepts coordinates and sums the value noise octaves in a pipeline.
`default_nettype none
module fvn_noise #(
    parameter int OCTAVE_COUNT = 4
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  fvn_pkg::t_cfg                 i_cfg,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [15:0]                   i_grid_x,
    input  wire  [15:0]                   i_grid_y,
    output logic                          o_s_valid,
    input  wire                           i_s_ready,
    output logic [OCTAVE_COUNT+24-1:0]    o_s
);
    localparam int OIW = (OCTAVE_COUNT > 1) ? $clog2(OCTAVE_COUNT) : 1;
    localparam int PW  = 32 + OCTAVE_COUNT - 1;
    localparam int SW  = OCTAVE_COUNT + 24;

    logic            r_busy, r_issue;
    logic [OIW-1:0]  r_cnt;
    logic [31:0]     r_px, r_py;
    logic            r_s_valid;
    logic [SW-1:0]   r_s, r_sum;

    logic           r_v    [1:5];
    logic [OIW-1:0] r_oct  [1:5];
    logic           r_last [1:5];

    logic [31:0] r1_xa, r1_yb, r1_sc, r1_ttx, r1_tty;
    logic [15:0] r1_tx, r1_ty;
    logic [31:0] r2_g [4];
    logic [49:0] r2_fx, r2_fy;
    logic [31:0] r3_m [4];
    logic [16:0] r3_u, r3_v;
    logic [40:0] r4_p [4];
    logic [16:0] r4_v;
    logic [58:0] r5_mlo, r5_mhi;

    logic           w_acc;
    logic [PW-1:0]  w_shx, w_shy;
    logic [31:0]    w_xi, w_yi, w_seed, w_base;
    logic [31:0]    w_h [4];
    logic [17:0]    w_wx, w_wy;
    logic [23:0]    w_c [4];
    logic [41:0]    w_lo, w_hi;
    logic [24:0]    w_noise;
    logic [OIW-1:0] w_shamt;
    logic [SW-1:0]  w_term, w_sum;

    assign o_ready   = !r_busy && !r_s_valid;
    assign w_acc     = i_valid && o_ready;
    assign o_s_valid = r_s_valid;
    assign o_s       = r_s;

    always_comb begin
        w_shx  = PW'(r_px) << r_cnt;
        w_shy  = PW'(r_py) << r_cnt;
        w_xi   = 32'(w_shx[PW-1:16]);
        w_yi   = 32'(w_shy[PW-1:16]);
        w_seed = i_cfg.seed + 32'(r_cnt) * fvn_pkg::SEED_STEP;
        w_base = r1_xa + r1_yb + r1_sc;
        w_h[0] = w_base;
        w_h[1] = w_base + fvn_pkg::HASH_X;
        w_h[2] = w_base + fvn_pkg::HASH_Y;
        w_h[3] = w_base + fvn_pkg::HASH_X + fvn_pkg::HASH_Y;
        w_wx   = 18'd196608 - {1'b0, r1_tx, 1'b0};
        w_wy   = 18'd196608 - {1'b0, r1_ty, 1'b0};
        for (int k = 0; k < 4; k++) begin
            w_c[k] = r3_m[k][23:0] ^ {8'd0, r3_m[k][31:16]};
        end
        w_lo    = 42'(r4_p[0]) + 42'(r4_p[1]);
        w_hi    = 42'(r4_p[2]) + 42'(r4_p[3]);
        w_noise = 25'((60'(r5_mlo) + 60'(r5_mhi) + 60'h80000000) >> 32);
        w_shamt = OIW'(OCTAVE_COUNT - 1) - r_oct[5];
        w_term  = SW'(w_noise) << w_shamt;
        w_sum   = (r_oct[5] == '0) ? w_term : r_sum + w_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issue   <= 1'b0;
            r_s_valid <= 1'b0;
            for (int k = 1; k <= 5; k++) r_v[k] <= 1'b0;
        end else begin
            if (w_acc) begin
                r_busy  <= 1'b1;
                r_issue <= 1'b1;
                r_cnt   <= '0;
                r_px    <= {16'd0, i_grid_x} * {16'd0, i_cfg.scale};
                r_py    <= {16'd0, i_grid_y} * {16'd0, i_cfg.scale};
            end else if (r_issue) begin
                r_cnt <= r_cnt + OIW'(1);
                if (r_cnt == OIW'(OCTAVE_COUNT - 1)) r_issue <= 1'b0;
            end
            r_v[1]    <= r_issue;
            r_oct[1]  <= r_cnt;
            r_last[1] <= (r_cnt == OIW'(OCTAVE_COUNT - 1));
            for (int k = 2; k <= 5; k++) begin
                r_v[k]    <= r_v[k-1];
                r_oct[k]  <= r_oct[k-1];
                r_last[k] <= r_last[k-1];
            end
            if (r_s_valid && i_s_ready) r_s_valid <= 1'b0;
            if (r_v[5]) begin
                r_sum <= w_sum;
                if (r_last[5]) begin
                    r_s       <= w_sum;
                    r_s_valid <= 1'b1;
                    r_busy    <= 1'b0;
                end
            end
        end
    end

    // Datapath stages, one multiplier rank per stage.
    always_ff @(posedge i_clk) begin
        r1_xa  <= w_xi * fvn_pkg::HASH_X;
        r1_yb  <= w_yi * fvn_pkg::HASH_Y;
        r1_sc  <= w_seed * fvn_pkg::HASH_S;
        r1_tx  <= w_shx[15:0];
        r1_ty  <= w_shy[15:0];
        r1_ttx <= {16'd0, w_shx[15:0]} * {16'd0, w_shx[15:0]};
        r1_tty <= {16'd0, w_shy[15:0]} * {16'd0, w_shy[15:0]};
        for (int k = 0; k < 4; k++) begin
            r2_g[k] <= w_h[k] ^ (w_h[k] >> 13);
            r3_m[k] <= r2_g[k] * fvn_pkg::HASH_MIX;
        end
        r2_fx   <= 50'(r1_ttx) * 50'(w_wx);
        r2_fy   <= 50'(r1_tty) * 50'(w_wy);
        r3_u    <= 17'((r2_fx + 50'h80000000) >> 32);
        r3_v    <= 17'((r2_fy + 50'h80000000) >> 32);
        r4_p[0] <= 41'(w_c[0]) * 41'(17'd65536 - r3_u);
        r4_p[1] <= 41'(w_c[1]) * 41'(r3_u);
        r4_p[2] <= 41'(w_c[2]) * 41'(17'd65536 - r3_u);
        r4_p[3] <= 41'(w_c[3]) * 41'(r3_u);
        r4_v    <= r3_v;
        r5_mlo  <= 59'(w_lo) * 59'(17'd65536 - r4_v);
        r5_mhi  <= 59'(w_hi) * 59'(r4_v);
    end
endmodule
`default_nettype wire

/* hw/rtl/fvn_height.sv */
// Turns a weighted noise sum into a clamped terrain height with a reciprocal multiply.
`default_nettype none
module fvn_height #(
    parameter int OCTAVE_COUNT = 4
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  fvn_pkg::t_cfg               i_cfg,
    input  wire                         i_s_valid,
    output logic                        o_s_ready,
    input  wire  [OCTAVE_COUNT+24-1:0]  i_s,
    output logic                        o_h_valid,
    input  wire                         i_h_ready,
    output logic [5:0]                  o_h
);
    localparam int SW = OCTAVE_COUNT + 24;
    localparam int XW = SW + 8;
    localparam int YW = XW - 25;
    localparam int RK = 24;
    localparam int PW = YW + RK + 1;
    localparam logic [63:0]   WSUM  = (64'd1 << OCTAVE_COUNT) - 64'd1;
    localparam logic [XW-1:0] DEN   = XW'(WSUM << 24);
    localparam logic [RK:0]   RECIP = (RK+1)'(((64'd1 << RK) + WSUM - 64'd1) / WSUM);

    logic          r_busy, r_done;
    logic [YW-1:0] r_y;
    logic [5:0]    r_q;
    logic [XW-1:0] w_num;
    logic [PW-1:0] w_prod;
    logic          w_take;

    assign o_s_ready = !r_busy && !r_done;
    assign w_take    = i_s_valid && o_s_ready;
    // The height is 2*S*(depth-1) + W*2^24 over 2*W*2^24, which rounds half up.
    assign w_num     = ((XW'(i_s) << 1) * XW'(i_cfg.dm1)) + DEN;
    // The power of two is dropped first; the rounded-up reciprocal of W is exact
    // over the whole range of the remaining numerator.
    assign w_prod    = PW'(r_y) * PW'(RECIP);
    assign o_h_valid = r_done;
    // The quotient is already rounded; clamp it to 1..depth-1.
    assign o_h = (r_q == 6'd0) ? 6'd1 : ((r_q > i_cfg.dm1) ? i_cfg.dm1 : r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= w_take;
            if (r_busy) begin
                r_done <= 1'b1;
            end else if (i_h_ready) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_y <= w_num[XW-1:25];
        if (r_busy) r_q <= w_prod[RK+5:RK];
    end
endmodule
`default_nettype wire

/* hw/rtl/fvn_queue.sv */
// Short height queue between the front part and the column emitter.
`default_nettype none
module fvn_queue (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push_valid,
    output logic       o_push_ready,
    input  wire  [5:0] i_data,
    output logic       o_pop_valid,
    input  wire        i_pop_ready,
    output logic [5:0] o_data
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [5:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_push_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_data       = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= r_wp + AW'(1);
            end
            if (w_pop) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/fvn_column.sv */
// Back part: emits one cube per level of each column, one level per cycle unless stalled.
`default_nettype none
module fvn_column (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  fvn_pkg::t_cfg i_cfg,
    input  wire           i_h_valid,
    output logic          o_h_ready,
    input  wire  [5:0]    i_h,
    output logic          o_valid,
    input  wire           i_ready,
    output logic [5:0]    o_level,
    output logic [15:0]   o_cube_id,
    output logic [5:0]    o_terrain_height,
    output logic          o_last_level
);
    logic        r_act, r_ov;
    logic [5:0]  r_z, r_h;
    logic [5:0]  r_level, r_height;
    logic [15:0] r_cube;
    logic        r_last;

    logic        w_load, w_have, w_last;
    logic [5:0]  w_z, w_hh, w_wtop;
    logic [15:0] w_cube;

    assign w_load    = !r_ov || i_ready;
    assign w_have    = r_act || i_h_valid;
    assign o_h_ready = w_load && !r_act;
    assign w_z       = r_act ? r_z : 6'd0;
    assign w_hh      = r_act ? r_h : i_h;
    assign w_last    = (w_z == i_cfg.dm1);
    assign w_wtop    = (i_cfg.sea > i_cfg.dm1) ? i_cfg.dm1 : i_cfg.sea;

    always_comb begin
        if ((7'(w_z) + 7'd1) < 7'(w_hh)) begin
            w_cube = i_cfg.under;
        end else if ((7'(w_z) + 7'd1) == 7'(w_hh)) begin
            w_cube = i_cfg.surface;
        end else if (i_cfg.water != 16'd0 && (w_hh - 6'd1) < i_cfg.sea && w_z <= w_wtop) begin
            w_cube = i_cfg.water;
        end else begin
            w_cube = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_act <= 1'b0;
        end else if (w_load) begin
            r_ov <= w_have;
            if (w_have) begin
                r_act    <= !w_last;
                r_z      <= w_z + 6'd1;
                r_h      <= w_hh;
                r_level  <= w_z;
                r_cube   <= w_cube;
                r_height <= w_hh;
                r_last   <= w_last;
            end
        end
    end

    assign o_valid          = r_ov;
    assign o_level          = r_level;
    assign o_cube_id        = r_cube;
    assign o_terrain_height = r_height;
    assign o_last_level     = r_last;
endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the fractal value noise terrain column generator.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    // One result of a column, as the block should emit it.
    typedef struct packed {
        logic [5:0]  level;
        logic [15:0] cube_id;
        logic [5:0]  height;
        logic        last;
    } t_level;

    // The scoreboard holds its own copy of the registers, computes each column
    // from an accepted request, and compares emitted levels in order.
    class column_scoreboard;
        logic [31:0] seed;
        logic [15:0] scale;
        logic [6:0]  depth_reg;
        logic [5:0]  sea;
        logic [15:0] surface;
        logic [15:0] under;
        logic [15:0] water;
        t_level      pending[$];
        int          errors;

        function void reset_regs();
            seed = 32'd1337; scale = 16'd5243; depth_reg = 7'd16; sea = 6'd5;
            surface = 16'd1; under = 16'd2; water = 16'd0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                fvn_pkg::REG_SEED:        seed = data;
                fvn_pkg::REG_SCALE:       scale = data[15:0];
                fvn_pkg::REG_DEPTH:       depth_reg = data[6:0];
                fvn_pkg::REG_SEA:         sea = data[5:0];
                fvn_pkg::REG_SURFACE:     surface = data[15:0];
                fvn_pkg::REG_UNDERGROUND: under = data[15:0];
                fvn_pkg::REG_WATER:       water = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] lattice_hash(logic [31:0] x, logic [31:0] y, logic [31:0] s);
            logic [31:0] h;
            h = x * fvn_pkg::HASH_X + y * fvn_pkg::HASH_Y + s * fvn_pkg::HASH_S;
            h = (h ^ (h >> 13)) * fvn_pkg::HASH_MIX;
            return h ^ (h >> 16);
        endfunction

        function logic [63:0] smooth(logic [63:0] t);
            logic [63:0] w;
            w = (64'd3 << 16) - 2 * t;
            return (t * t * w + 64'h8000_0000) >> 32;
        endfunction

        function logic [63:0] octave_value(logic [63:0] px, logic [63:0] py, logic [31:0] s);
            logic [31:0] xi, yi;
            logic [63:0] u, v, a, b, c, d, lo, hi, mix;
            xi = px[47:16]; yi = py[47:16];
            u = smooth(px & 64'hFFFF); v = smooth(py & 64'hFFFF);
            a = lattice_hash(xi, yi, s) & 32'hFFFFFF;
            b = lattice_hash(xi + 1, yi, s) & 32'hFFFFFF;
            c = lattice_hash(xi, yi + 1, s) & 32'hFFFFFF;
            d = lattice_hash(xi + 1, yi + 1, s) & 32'hFFFFFF;
            lo = a * (65536 - u) + b * u;
            hi = c * (65536 - u) + d * u;
            mix = lo * (65536 - v) + hi * v;
            return (mix + 64'h8000_0000) >> 32;
        endfunction

        function void note_request(logic [15:0] gx, logic [15:0] gy);
            logic [63:0] px, py, sum, den, h, wtop, wsum;
            logic [15:0] cube;
            int depth;
            t_level r;
            px = gx * scale; py = gy * scale;
            depth = int'(depth_reg);
            if (depth < 2) depth = 2;
            if (depth > 64) depth = 64;
            sum = 0; wsum = 0;
            for (int i = 0; i < 4; i++) begin
                sum += (64'd1 << (3 - i)) *
                       octave_value(px << i, py << i, seed + i * fvn_pkg::SEED_STEP);
                wsum += 64'd1 << (3 - i);
            end
            den = wsum << 24;
            h = (2 * sum * (depth - 1) + den) / (2 * den);
            if (h < 1) h = 1;
            if (h > depth - 1) h = depth - 1;
            wtop = sea;
            if (wtop > depth - 1) wtop = depth - 1;
            for (int z = 0; z < depth; z++) begin
                cube = 16'd0;
                if (z + 1 < h) cube = under;
                else if (z + 1 == h) cube = surface;
                else if (water != 0 && h - 1 < sea && z <= wtop) cube = water;
                r.level = 6'(z); r.cube_id = cube; r.height = 6'(h); r.last = (z == depth - 1);
                pending = {pending, r};
            end
        endfunction

        function void check_level(t_level got);
            t_level exp_r;
            if (pending.size() == 0) begin
                $error("unexpected level %0d", got.level);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.level !== exp_r.level) begin
                $error("level: expected %0d actual %0d", exp_r.level, got.level); errors++;
            end
            if (got.cube_id !== exp_r.cube_id) begin
                $error("cube_id: expected %0d actual %0d", exp_r.cube_id, got.cube_id); errors++;
            end
            if (got.height !== exp_r.height) begin
                $error("terrain_height: expected %0d actual %0d", exp_r.height, got.height);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $error("last_level: expected %0d actual %0d", exp_r.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic [15:0] i_grid_x = '0;
    logic [15:0] i_grid_y = '0;
    logic        i_ready = 0;
    wire         o_cfg_ready, o_ready, o_valid, o_last_level;
    wire  [5:0]  o_level, o_terrain_height;
    wire  [15:0] o_cube_id;

    fbm_value_noise_terrain_column_core dut (.*);

    always #2 i_clk = ~i_clk;

    column_scoreboard board = new();
    int  cycle_count = 0;
    bit  quiet_mode = 0;     // No idling on either side near the end of the run.
    int  hold_off = 0;       // Cycles the receiver still refuses levels.

    // Timeout watchdog: generous bound over 64 levels per column with long stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000) begin
            $display("fbm_value_noise_terrain_column_core regression: fail");
            $finish;
        end
    end

    // Output side: sample at the rising edge and check every accepted level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_level('{o_level, o_cube_id, o_terrain_height, o_last_level});
    end

    // Receiver readiness changes at the falling edge, with random stall bursts
    // and one long hold-off that lets the block fill up.
    initial begin
        int burst;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                i_ready <= 0;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 18);
                i_ready <= 0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1;
            end
        end
    end

    task automatic write_register(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // Send one column request; the valid line stays high across back-to-back requests.
    task automatic send_column(logic [15:0] gx, logic [15:0] gy);
        if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_valid <= 1; i_grid_x <= gx; i_grid_y <= gy;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(gx, gy);
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic random_columns(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) == 0)
                send_column($urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 40)),
                            16'($urandom));
            else
                send_column(16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        board.reset_regs();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: default settings, coordinate extremes.
        send_column(0, 0);
        send_column(16'hFFFF, 16'hFFFF);
        send_column(16'hFFFF, 0);
        send_column(0, 16'hFFFF);
        send_column(16'h5555, 16'hAAAA);
        drain();

        // Water enabled with the sea above the column; tiny depth, zero surface and underground ids.
        write_register(fvn_pkg::REG_WATER, 32'd9);
        write_register(fvn_pkg::REG_SEA, 32'd63);
        write_register(fvn_pkg::REG_DEPTH, 32'd2);
        write_register(fvn_pkg::REG_SURFACE, 32'd0);
        write_register(fvn_pkg::REG_UNDERGROUND, 32'd0);
        send_column(1, 2);
        send_column(16'hFFFF, 16'h1234);
        drain();

        // Depth out of range on both sides, full scale, seed extremes, unknown index.
        write_register(fvn_pkg::REG_DEPTH, 32'd0);
        write_register(fvn_pkg::REG_SEED, 32'hFFFF_FFFF);
        write_register(fvn_pkg::REG_SCALE, 32'hFFFF);
        write_register(fvn_pkg::REG_SURFACE, 32'hFFFF);
        write_register(fvn_pkg::REG_UNDERGROUND, 32'hFFFF);
        write_register(3'd7, 32'hDEAD_BEEF);
        send_column(7, 9);
        drain();
        write_register(fvn_pkg::REG_SEED, 32'd0);
        write_register(fvn_pkg::REG_DEPTH, 32'd127);
        write_register(fvn_pkg::REG_SEA, 32'd0);
        write_register(fvn_pkg::REG_WATER, 32'hFFFF);
        send_column(16'hFFFF, 16'hFFFF);
        send_column(3, 3);
        drain();
        write_register(fvn_pkg::REG_SCALE, 32'd1);
        send_column(16'hFFFF, 16'h8000);
        drain();

        // Random phases over several register settings; small depths dominate.
        for (int phase = 0; phase < 6; phase++) begin
            write_register(fvn_pkg::REG_SEED, $urandom);
            write_register(fvn_pkg::REG_SCALE, $urandom_range(0, 4) == 0 ? 32'hFFFF : $urandom);
            write_register(fvn_pkg::REG_DEPTH, phase == 2 ? 64 : $urandom_range(0, 20));
            write_register(fvn_pkg::REG_SEA, $urandom);
            write_register(fvn_pkg::REG_SURFACE, $urandom);
            write_register(fvn_pkg::REG_UNDERGROUND, $urandom);
            write_register(fvn_pkg::REG_WATER, $urandom_range(0, 2) == 0 ? 0 : $urandom);
            if (phase == 1) begin
                hold_off = 400;
            end
            if (phase == 5) quiet_mode = 1;
            random_columns(phase == 2 ? 15 : 40);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("fbm_value_noise_terrain_column_core regression: pass");
        else
            $display("fbm_value_noise_terrain_column_core regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
